[rtl/sqvg_pkg.sv]
`default_nettype none
package sqvg_pkg;

    // Vertex count per sprite and vertex index coding
    localparam int VERTS_PER_SPRITE = 6;
    localparam int VNUM_W           = 3;
    localparam logic [VNUM_W-1:0] VNUM_LAST = VNUM_W'(VERTS_PER_SPRITE - 1);

    // Angle resolution kept from the 16-bit turn input
    localparam int ANGLE_BITS = 16;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // Quarter-wave sine polynomial coefficients, Q1.30
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [30:0] SIN_B = 31'd693598668;
    localparam logic [30:0] SIN_C = 31'd85569306;
    localparam logic [30:0] SIN_D = 31'd4858527;

    localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;

    // Corner of each vertex: bit 0 right side, bit 1 bottom side
    function automatic logic [1:0] corner_of(input logic [VNUM_W-1:0] vnum);
        logic [1:0] c;
        case (vnum)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd2;
            3'd4:    c = 2'd1;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // One sprite as held by the vertex sequencer
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [23:0]        width;
        logic [23:0]        height;
        logic [31:0]        uv_start;
        logic [31:0]        uv_end;
        logic [31:0]        tint_rgba;
        logic               transform_on;
        logic [31:0]        pivot_xy;
        logic [31:0]        scale_xy;
        logic [15:0]        angle;
    } sprite_t;

    // One vertex in flight through the datapath
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic [23:0]        w;
        logic [23:0]        h;
        logic [1:0]         corner;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        tint;
        logic [VNUM_W-1:0]  num;
        logic               last;
        logic               xf;
        logic [15:0]        piv_x;
        logic [15:0]        piv_y;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               neg_s;
        logic               neg_c;
        logic [30:0]        fs;
        logic [30:0]        fc;
        logic [30:0]        x2s;
        logic [30:0]        x2c;
        logic [30:0]        ts;
        logic [30:0]        tc;
        logic [24:0]        px;
        logic [24:0]        py;
        logic signed [41:0] tx;
        logic signed [41:0] ty;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
        logic signed [59:0] p_xc;
        logic signed [59:0] p_ys;
        logic signed [59:0] p_xs;
        logic signed [59:0] p_yc;
    } vtx_t;

endpackage
`default_nettype wire

[rtl/sprite_quad_vertex_generator.sv]
// Sprite quad vertex generator.
// Input channel (s_*): one sprite per beat: origin, size, texture window,
// tint, and optional pivot/scale/rotation. Output channel (m_*): six vertex
// beats per sprite, two triangles (0,0),(w,0),(0,h),(0,h),(w,0),(w,h), each
// with position, texture coordinate, tint, vertex number and a last flag.
// A sprite is held in a sequencer that issues one vertex per cycle into an
// eight-register datapath (pivot and offset products, the four-step sine
// polynomial, the rotation products, then sum and saturation).
// Throughput: one vertex per cycle while the output is not stalled; the next
// sprite is taken in the cycle its predecessor's last vertex is issued.
// When m_ready is low with a vertex waiting, the whole datapath and the
// sequencer hold; a sprite is then taken only while the sequencer is idle.
// Reset (aresetn low, synchronous) empties the sequencer and all stages.
`default_nettype none
module sprite_quad_vertex_generator
    import sqvg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_origin_x,
    input  wire logic signed [31:0] s_origin_y,
    input  wire logic [23:0]        s_width,
    input  wire logic [23:0]        s_height,
    input  wire logic [31:0]        s_uv_start,
    input  wire logic [31:0]        s_uv_end,
    input  wire logic [31:0]        s_tint_rgba,
    input  wire logic               s_transform_on,
    input  wire logic [31:0]        s_pivot_xy,
    input  wire logic [31:0]        s_scale_xy,
    input  wire logic [15:0]        s_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_vertex_x,
    output logic signed [31:0]      m_vertex_y,
    output logic [15:0]             m_tex_u,
    output logic [15:0]             m_tex_v,
    output logic [31:0]             m_vertex_tint,
    output logic [VNUM_W-1:0]       m_vertex_number,
    output logic                    m_last_vertex
);

    localparam int NSTG = 7;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic                adv;
    logic                s_fire;

    sprite_t             spr_reg, spr_next;
    logic                busy_reg, busy_next;
    logic [VNUM_W-1:0]   vcnt_reg, vcnt_next;

    vtx_t                pipe_reg  [1:NSTG];
    vtx_t                pipe_next [1:NSTG];
    logic [NSTG:1]       vld_reg;

    logic                out_vld_reg;
    logic signed [31:0]  out_x_reg, out_x_next;
    logic signed [31:0]  out_y_reg, out_y_next;
    logic [15:0]         out_u_reg;
    logic [15:0]         out_v_reg;
    logic [31:0]         out_tint_reg;
    logic [VNUM_W-1:0]   out_num_reg;
    logic                out_last_reg;

    // Whole datapath moves together unless a finished beat is stuck
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = !busy_reg || (adv && vcnt_reg == VNUM_LAST);
    assign s_fire  = s_valid && s_ready;

    // Vertex sequencer
    always_comb begin
        spr_next  = spr_reg;
        busy_next = busy_reg;
        vcnt_next = vcnt_reg;
        if (adv && busy_reg) begin
            if (vcnt_reg == VNUM_LAST) begin
                busy_next = 1'b0;
                vcnt_next = '0;
            end else begin
                vcnt_next = vcnt_reg + 1'b1;
            end
        end
        if (s_fire) begin
            busy_next = 1'b1;
            vcnt_next = '0;
            spr_next  = '{origin_x: s_origin_x, origin_y: s_origin_y,
                          width: s_width, height: s_height,
                          uv_start: s_uv_start, uv_end: s_uv_end,
                          tint_rgba: s_tint_rgba, transform_on: s_transform_on,
                          pivot_xy: s_pivot_xy, scale_xy: s_scale_xy,
                          angle: s_angle};
        end
    end

    // Stage 1: corner, texture select, angle folding into quarter wave
    always_comb begin
        logic [31:0] ph_s;
        logic [31:0] ph_c;
        logic [1:0]  crn;
        vtx_t        v;
        ph_s = {spr_reg.angle, 16'h0000} & ANGLE_MASK;
        ph_c = ph_s + 32'h4000_0000;
        crn  = corner_of(vcnt_reg);
        v        = '0;
        v.ox     = spr_reg.origin_x;
        v.oy     = spr_reg.origin_y;
        v.w      = spr_reg.width;
        v.h      = spr_reg.height;
        v.corner = crn;
        v.tex_u  = crn[0] ? spr_reg.uv_end[15:0]  : spr_reg.uv_start[15:0];
        v.tex_v  = crn[1] ? spr_reg.uv_end[31:16] : spr_reg.uv_start[31:16];
        v.tint   = spr_reg.tint_rgba;
        v.num    = vcnt_reg;
        v.last   = (vcnt_reg == VNUM_LAST);
        v.xf     = spr_reg.transform_on;
        v.piv_x  = spr_reg.pivot_xy[15:0];
        v.piv_y  = spr_reg.pivot_xy[31:16];
        v.sx     = spr_reg.scale_xy[15:0];
        v.sy     = spr_reg.scale_xy[31:16];
        v.neg_s  = ph_s[31];
        v.neg_c  = ph_c[31];
        v.fs     = ph_s[30] ? QUARTER_TURN - {1'b0, ph_s[29:0]} : {1'b0, ph_s[29:0]};
        v.fc     = ph_c[30] ? QUARTER_TURN - {1'b0, ph_c[29:0]} : {1'b0, ph_c[29:0]};
        pipe_next[1] = v;
    end

    // Stage 2: x^2 for both waves, pivot offsets
    always_comb begin
        logic [63:0] ms;
        logic [63:0] mc;
        logic [40:0] mpx;
        logic [40:0] mpy;
        vtx_t        v;
        v   = pipe_reg[1];
        ms  = 64'(v.fs) * 64'(v.fs);
        mc  = 64'(v.fc) * 64'(v.fc);
        mpx = 41'(v.piv_x) * 41'(v.w) + 41'd16384;
        mpy = 41'(v.piv_y) * 41'(v.h) + 41'd16384;
        v.x2s = 31'(ms >> 30);
        v.x2c = 31'(mc >> 30);
        v.px  = 25'(mpx >> 15);
        v.py  = 25'(mpy >> 15);
        pipe_next[2] = v;
    end

    // Stage 3: innermost polynomial term, scaled corner offsets
    always_comb begin
        logic [63:0]        ms;
        logic [63:0]        mc;
        logic signed [25:0] dx;
        logic signed [25:0] dy;
        vtx_t               v;
        v  = pipe_reg[2];
        ms = 64'(SIN_D) * 64'(v.x2s);
        mc = 64'(SIN_D) * 64'(v.x2c);
        dx = (v.corner[0] ? $signed({2'b00, v.w}) : 26'sd0) - $signed({1'b0, v.px});
        dy = (v.corner[1] ? $signed({2'b00, v.h}) : 26'sd0) - $signed({1'b0, v.py});
        v.ts = SIN_C - 31'(ms >> 30);
        v.tc = SIN_C - 31'(mc >> 30);
        v.tx = 42'(dx) * 42'(v.sx);
        v.ty = 42'(dy) * 42'(v.sy);
        pipe_next[3] = v;
    end

    // Stage 4: second polynomial term
    always_comb begin
        logic [63:0] ms;
        logic [63:0] mc;
        vtx_t        v;
        v  = pipe_reg[3];
        ms = 64'(v.ts) * 64'(v.x2s);
        mc = 64'(v.tc) * 64'(v.x2c);
        v.ts = SIN_B - 31'(ms >> 30);
        v.tc = SIN_B - 31'(mc >> 30);
        pipe_next[4] = v;
    end

    // Stage 5: third polynomial term
    always_comb begin
        logic [63:0] ms;
        logic [63:0] mc;
        vtx_t        v;
        v  = pipe_reg[4];
        ms = 64'(v.ts) * 64'(v.x2s);
        mc = 64'(v.tc) * 64'(v.x2c);
        v.ts = SIN_A - 31'(ms >> 30);
        v.tc = SIN_A - 31'(mc >> 30);
        pipe_next[5] = v;
    end

    // Stage 6: final multiply, round to Q1.15, cap, apply quadrant sign
    always_comb begin
        logic [63:0] ms;
        logic [63:0] mc;
        logic [33:0] qs;
        logic [33:0] qc;
        logic [18:0] rs;
        logic [18:0] rc;
        logic [16:0] as;
        logic [16:0] ac;
        vtx_t        v;
        v  = pipe_reg[5];
        ms = 64'(v.ts) * 64'(v.fs);
        mc = 64'(v.tc) * 64'(v.fc);
        qs = 34'(ms >> 30) + 34'd16384;
        qc = 34'(mc >> 30) + 34'd16384;
        rs = 19'(qs >> 15);
        rc = 19'(qc >> 15);
        as = (rs > 19'd32768) ? 17'd32768 : rs[16:0];
        ac = (rc > 19'd32768) ? 17'd32768 : rc[16:0];
        v.sn = v.neg_s ? -$signed(as) : $signed(as);
        v.cs = v.neg_c ? -$signed(ac) : $signed(ac);
        pipe_next[6] = v;
    end

    // Stage 7: rotation products
    always_comb begin
        vtx_t v;
        v = pipe_reg[6];
        v.p_xc = 60'(v.tx) * 60'(v.cs);
        v.p_ys = 60'(v.ty) * 60'(v.sn);
        v.p_xs = 60'(v.tx) * 60'(v.sn);
        v.p_yc = 60'(v.ty) * 60'(v.cs);
        pipe_next[7] = v;
    end

    // Output stage: sum, round off the Q8.8 scale and Q1.15 sine fractions, translate, saturate
    always_comb begin
        logic signed [63:0] rx;
        logic signed [63:0] ry;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        vtx_t               v;
        v  = pipe_reg[7];
        rx = (64'(v.p_xc) - 64'(v.p_ys) + 64'sd4194304) >>> 23;
        ry = (64'(v.p_xs) + 64'(v.p_yc) + 64'sd4194304) >>> 23;
        if (v.xf) begin
            sx = 64'(v.ox) + rx + $signed({39'd0, v.px});
            sy = 64'(v.oy) + ry + $signed({39'd0, v.py});
        end else begin
            sx = 64'(v.ox) + (v.corner[0] ? $signed({40'd0, v.w}) : 64'sd0);
            sy = 64'(v.oy) + (v.corner[1] ? $signed({40'd0, v.h}) : 64'sd0);
        end
        out_x_next = sat32(sx);
        out_y_next = sat32(sy);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            vcnt_reg    <= '0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            vcnt_reg <= vcnt_next;
            if (adv) begin
                vld_reg     <= {vld_reg[NSTG-1:1], busy_reg};
                out_vld_reg <= vld_reg[NSTG];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        spr_reg <= spr_next;
        if (adv) begin
            for (int k = 1; k <= NSTG; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_u_reg    <= pipe_reg[NSTG].tex_u;
            out_v_reg    <= pipe_reg[NSTG].tex_v;
            out_tint_reg <= pipe_reg[NSTG].tint;
            out_num_reg  <= pipe_reg[NSTG].num;
            out_last_reg <= pipe_reg[NSTG].last;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_vertex_x      = out_x_reg;
    assign m_vertex_y      = out_y_reg;
    assign m_tex_u         = out_u_reg;
    assign m_tex_v         = out_v_reg;
    assign m_vertex_tint   = out_tint_reg;
    assign m_vertex_number = out_num_reg;
    assign m_last_vertex   = out_last_reg;

endmodule
`default_nettype wire

[rtl/sqvg_checker.sv]
`default_nettype none
module sqvg_checker
    import sqvg_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_vertex_x,
    input wire logic signed [31:0] m_vertex_y,
    input wire logic [VNUM_W-1:0]  m_vertex_number,
    input wire logic               m_last_vertex
);

    // Stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_x)
            && $stable(m_vertex_y) && $stable(m_vertex_number))
        else $error("stalled vertex beat changed");

    // Last flag marks exactly the sixth vertex
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_vertex == (m_vertex_number == VNUM_LAST)))
        else $error("last flag does not match vertex number");

    // Vertex numbers stay in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_vertex_number <= VNUM_LAST)
        else $error("vertex number out of range");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_vertex_x      (m_vertex_x),
    .m_vertex_y      (m_vertex_y),
    .m_vertex_number (m_vertex_number),
    .m_last_vertex   (m_last_vertex)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none

// Expected-vertex store for the sprite quad generator
class vertex_scoreboard;
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        tint;
        logic [2:0]         num;
        logic               last;
    } vertex_t;

    vertex_t pending_vertices[$];
    int      errors;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Quarter-wave polynomial, Q2.30
    function automatic longint poly_sine(longint x);
        longint x2, t;
        x2 = (x * x) >>> 30;
        t = (64'sd4858527 * x2) >>> 30;
        t = 64'sd85569306 - t;
        t = (t * x2) >>> 30;
        t = 64'sd693598668 - t;
        t = (t * x2) >>> 30;
        t = 64'sd1686629713 - t;
        return (t * x) >>> 30;
    endfunction

    function automatic longint turn_sine(logic [31:0] phase);
        logic [1:0] quad;
        longint f, s;
        quad = phase[31:30];
        f = longint'(phase[29:0]);
        if (quad[0]) f = 64'sh40000000 - f;
        s = (poly_sine(f) + 16384) >>> 15;
        if (s > 32768) s = 32768;
        return quad[1] ? -s : s;
    endfunction

    // Note one accepted sprite: queue its six vertices
    function void note_sprite(logic signed [31:0] ox_i, logic signed [31:0] oy_i,
                              logic [23:0] w_i, logic [23:0] h_i,
                              logic [31:0] uv0, logic [31:0] uv1, logic [31:0] tint,
                              logic xf, logic [31:0] piv, logic [31:0] scl,
                              logic [15:0] ang);
        longint ox, oy, w, h, px, py, sx, sy, sn, cs, lx, ly, tx, ty, rx, ry;
        longint cx[4], cy[4];
        logic [31:0] phase;
        logic [1:0] corner_map[6];
        vertex_t vtx;
        int sel;
        corner_map = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd3};
        ox = ox_i; oy = oy_i; w = w_i; h = h_i;
        px = (longint'(piv[15:0]) * w + 16384) >>> 15;
        py = (longint'(piv[31:16]) * h + 16384) >>> 15;
        sx = longint'($signed(scl[15:0]));
        sy = longint'($signed(scl[31:16]));
        phase = {ang, 16'h0} & sqvg_pkg::ANGLE_MASK;
        sn = turn_sine(phase);
        cs = turn_sine(phase + 32'h40000000);
        for (int c = 0; c < 4; c++) begin
            lx = c[0] ? w : 0;
            ly = c[1] ? h : 0;
            if (!xf) begin
                cx[c] = clamp32(ox + lx);
                cy[c] = clamp32(oy + ly);
            end else begin
                tx = (lx - px) * sx;
                ty = (ly - py) * sy;
                rx = floor_shr(tx * cs - ty * sn + (64'sd1 << 22), 23);
                ry = floor_shr(tx * sn + ty * cs + (64'sd1 << 22), 23);
                cx[c] = clamp32(ox + rx + px);
                cy[c] = clamp32(oy + ry + py);
            end
        end
        for (int k = 0; k < 6; k++) begin
            sel = corner_map[k];
            vtx.x = cx[sel][31:0];
            vtx.y = cy[sel][31:0];
            vtx.u = sel[0] ? uv1[15:0] : uv0[15:0];
            vtx.v = sel[1] ? uv1[31:16] : uv0[31:16];
            vtx.tint = tint;
            vtx.num = k[2:0];
            vtx.last = (k == 5);
            pending_vertices.push_back(vtx);
        end
    endfunction

    // Compare one vertex beat with the oldest expectation
    task check_vertex(vertex_t got);
        vertex_t exp_v;
        if (pending_vertices.size() == 0) begin
            report_mismatch("vertex beat with nothing expected", 0, 0);
            return;
        end
        exp_v = pending_vertices.pop_front();
        if (got.x != exp_v.x) report_mismatch("vertex_x", got.x, exp_v.x);
        if (got.y != exp_v.y) report_mismatch("vertex_y", got.y, exp_v.y);
        if (got.u != exp_v.u) report_mismatch("tex_u", got.u, exp_v.u);
        if (got.v != exp_v.v) report_mismatch("tex_v", got.v, exp_v.v);
        if (got.tint != exp_v.tint) report_mismatch("vertex_tint", got.tint, exp_v.tint);
        if (got.num != exp_v.num) report_mismatch("vertex_number", got.num, exp_v.num);
        if (got.last != exp_v.last) report_mismatch("last_vertex", got.last, exp_v.last);
    endtask

    task report_mismatch(string what, longint got, longint want);
        errors++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask
endclass

module testbench;
    import sqvg_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_origin_x = '0;
    logic signed [31:0] s_origin_y = '0;
    logic [23:0]        s_width = '0;
    logic [23:0]        s_height = '0;
    logic [31:0]        s_uv_start = '0;
    logic [31:0]        s_uv_end = '0;
    logic [31:0]        s_tint_rgba = '0;
    logic               s_transform_on = 1'b0;
    logic [31:0]        s_pivot_xy = '0;
    logic [31:0]        s_scale_xy = '0;
    logic [15:0]        s_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_vertex_x;
    logic signed [31:0] m_vertex_y;
    logic [15:0]        m_tex_u;
    logic [15:0]        m_tex_v;
    logic [31:0]        m_vertex_tint;
    logic [VNUM_W-1:0]  m_vertex_number;
    logic               m_last_vertex;

    vertex_scoreboard quad_sb = new();
    bit               sprites_done = 1'b0;

    sprite_quad_vertex_generator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Drive one sprite beat, after a random gap
    task automatic send_sprite(logic [31:0] ox, logic [31:0] oy, logic [23:0] w,
                               logic [23:0] h, logic [31:0] uv0, logic [31:0] uv1,
                               logic [31:0] tint, logic xf, logic [31:0] piv,
                               logic [31:0] scl, logic [15:0] ang);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_origin_x <= ox; s_origin_y <= oy; s_width <= w; s_height <= h;
        s_uv_start <= uv0; s_uv_end <= uv1; s_tint_rgba <= tint;
        s_transform_on <= xf; s_pivot_xy <= piv; s_scale_xy <= scl; s_angle <= ang;
        do @(posedge aclk); while (!s_ready);
        quad_sb.note_sprite(ox, oy, w, h, uv0, uv1, tint, xf, piv, scl, ang);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h7FFFFFFF;
            3: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_sprite();
        logic [31:0] ox, oy, piv, scl;
        logic [23:0] w, h;
        ox = pick_word(); oy = pick_word();
        if ($urandom_range(0, 2) != 0) begin
            ox = $signed(ox) >>> $urandom_range(0, 12);
            oy = $signed(oy) >>> $urandom_range(0, 12);
        end
        w = 24'($urandom); h = 24'($urandom);
        if ($urandom_range(0, 1)) begin
            w = w >> $urandom_range(0, 14);
            h = h >> $urandom_range(0, 14);
        end
        piv = $urandom_range(0, 3) == 0 ? $urandom : {1'b0, 15'($urandom), 1'b0, 15'($urandom)};
        scl = $urandom_range(0, 1) ? $urandom
                                   : {16'($signed(12'($urandom))), 16'($signed(12'($urandom)))};
        send_sprite(ox, oy, w, h, pick_word(), pick_word(), $urandom,
                    $urandom_range(0, 3) != 0, piv, scl, 16'($urandom));
    endtask

    // Stimulus
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: plain rectangle, extremes, quadrants, saturation, mirroring
        send_sprite(32'h100, 32'h200, 24'h1000, 24'h800, 32'h0000_0000, 32'h8000_8000,
                    32'h11223344, 1'b0, 32'h0, 32'h0, 16'h0);
        send_sprite(32'h7FFFFFFF, 32'h7FFFFF00, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        send_sprite(32'h80000000, 32'h80000000, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0,
                    1'b1, 32'h0, 32'h0, 16'h0);
        for (int q = 0; q < 8; q++)
            send_sprite(32'h1000, 32'h1000, 24'h4000, 24'h2000, 32'h0, 32'h8000_8000,
                        q, 1'b1, 32'h4000_4000, 32'h0100_0100, 16'(q * 16'h2000));
        send_sprite(32'h0, 32'h0, 24'h8000, 24'h8000, 32'h0, 32'h8000_8000, 32'h5,
                    1'b1, 32'h8000_8000, 32'hFF00_FF00, 16'h1234);
        send_sprite(32'h7FFFF000, 32'h80001000, 24'hFFFFFF, 24'hFFFFFF, 32'h0, 32'h0,
                    32'h6, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_8000, 16'h2000);
        send_sprite(32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF, 24'h1, 32'h0, 32'h0,
                    32'h7, 1'b1, 32'h0, 32'h8000_7FFF, 16'h6000);
        send_sprite(32'h0, 32'h0, 24'h100, 24'h100, 32'h0, 32'h0, 32'h8,
                    1'b1, 32'h0, 32'h0100_0100, 16'h0001);
        for (int i = 0; i < 270; i++)
            random_sprite();
        s_valid <= 1'b0;
        sprites_done = 1'b1;
    end

    // Vertex sink with random back-pressure
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            quad_sb.check_vertex({m_vertex_x, m_vertex_y, m_tex_u, m_tex_v,
                                  m_vertex_tint, m_vertex_number, m_last_vertex});
        end
    end

    // Completion
    initial begin
        wait (sprites_done);
        while (quad_sb.pending_vertices.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (quad_sb.errors == 0 && quad_sb.pending_vertices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
